// ===== rtl/core/gcrt_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrt_pkg: shared types and constants for the group centroid/radius table
// Command codes, status codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package gcrt_pkg;

  localparam int unsigned MaxMembersDefault = 64;
  localparam logic [16:0] HealthOne = 17'h10000;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_SET_ROLE = 3'd2,
    CMD_SET_POS  = 3'd3,
    CMD_SET_HLTH = 3'd4,
    CMD_RECOMP   = 3'd5,
    CMD_COHESION = 3'd6,
    CMD_UNUSED   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_SRCH    = 4'd1,  // compare entry at index with id
    OP_APPEND  = 4'd2,
    OP_SHIFT   = 4'd3,  // move entry idx+1 to idx
    OP_ROLE    = 4'd4,
    OP_POS     = 4'd5,
    OP_HLTH    = 4'd6,
    OP_SUM     = 4'd7,  // accumulate entry idx
    OP_DIVST   = 4'd8,  // start divide
    OP_DIVSTEP = 4'd9,
    OP_DIST    = 4'd10, // squared distance of entry idx, stage-fed
    OP_SQST    = 4'd11,
    OP_SQSTEP  = 4'd12,
    OP_CLEAR   = 4'd13,
    OP_LOAD    = 4'd14  // latch input item
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] idx;
    logic       coh;     // distance pass compares against check radius
    logic       dec;     // decrement total
  } dp_cmd_t;

  typedef struct packed {
    logic match;   // registered result of last search compare
    logic done;    // divide / sqrt finished
    logic dist_ok; // distance pipe produced results for all issued
    logic fail;    // cohesion failed so far
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/gcrt_ram.sv =====
// ----------------------------------------------------------------------------
// gcrt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gcrt_datapath.sv =====
// ----------------------------------------------------------------------------
// gcrt_datapath: table storage and arithmetic
// Member RAM, search compare, sums, divider, distance pipe and square root.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrt_datapath import gcrt_pkg::*; #(
  parameter int unsigned MaxMembers = MaxMembersDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  input  wire logic [63:0]        entity_id_i,
  input  wire logic [3:0]         role_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] health_in_i,
  input  wire logic [31:0]        check_radius_i,
  output      dp_sts_t            sts_o,
  output      logic [7:0]         total_o,
  output      logic signed [31:0] cx_o,
  output      logic signed [31:0] cy_o,
  output      logic signed [31:0] cz_o,
  output      logic [31:0]        radius_o
);

  localparam int unsigned AW = (MaxMembers > 1) ? $clog2(MaxMembers) : 1;
  localparam int unsigned RW = 64 + 32 + 32 + 32 + 4 + 17;

  // latched input
  logic [63:0]        id_q;
  logic [3:0]         role_q;
  logic signed [31:0] px_q, py_q, pz_q, hin_q;
  logic [31:0]        crad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      id_q <= entity_id_i; role_q <= role_i;
      px_q <= pos_x_i; py_q <= pos_y_i; pz_q <= pos_z_i;
      hin_q <= health_in_i; crad_q <= check_radius_i;
    end
  end

  // total count
  logic [7:0] total_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) total_q <= '0;
    else if (cmd_i.op == OP_APPEND) total_q <= total_q + 8'd1;
    else if (cmd_i.dec) total_q <= total_q - 8'd1;
  end
  assign total_o = total_q;

  // one wide RAM holding a whole entry
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [63:0]        r_id;
  logic signed [31:0] r_px, r_py, r_pz;
  logic [3:0]         r_role;
  logic [16:0]        r_h;
  assign {r_id, r_px, r_py, r_pz, r_role, r_h} = rdata;

  logic [16:0] hclamp;
  always_comb begin
    if (hin_q < 0) hclamp = 17'd0;
    else if (hin_q > $signed({15'd0, HealthOne})) hclamp = HealthOne;
    else hclamp = hin_q[16:0];
  end

  always_comb begin
    we = 1'b1;
    waddr = cmd_i.idx[AW-1:0];
    wdata = rdata;
    raddr = cmd_i.idx[AW-1:0];
    unique case (cmd_i.op)
      OP_APPEND: begin
        waddr = total_q[AW-1:0];
        wdata = {id_q, 32'd0, 32'd0, 32'd0, role_q, HealthOne};
      end
      OP_SHIFT: wdata = rdata;  // data read from idx+1 last cycle
      OP_ROLE:  wdata = {r_id, r_px, r_py, r_pz, role_q, r_h};
      OP_POS:   wdata = {r_id, px_q, py_q, pz_q, r_role, r_h};
      OP_HLTH:  wdata = {r_id, r_px, r_py, r_pz, r_role, hclamp};
      default:  we = 1'b0;
    endcase
  end

  gcrt_ram #(.Width(RW), .Depth(MaxMembers)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic match_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SRCH) match_q <= (r_id == id_q);
  end

  // sums
  logic signed [39:0] sx_q, sy_q, sz_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) begin
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
    end else if (cmd_i.op == OP_SUM) begin
      sx_q <= sx_q + 40'(r_px); sy_q <= sy_q + 40'(r_py); sz_q <= sz_q + 40'(r_pz);
    end
  end

  // restoring divider, three magnitudes in parallel, 40 steps
  logic [39:0] qx_q, qy_q, qz_q, rx_q, ry_q, rz_q;
  logic [2:0]  neg_q;
  logic [5:0]  dcnt_q;
  logic [40:0] tx, ty, tz;
  assign tx = {rx_q, qx_q[39]} - {33'd0, total_q};
  assign ty = {ry_q, qy_q[39]} - {33'd0, total_q};
  assign tz = {rz_q, qz_q[39]} - {33'd0, total_q};

  logic [39:0] qxn, qyn, qzn;
  assign qxn = {qx_q[38:0], ~tx[40]};
  assign qyn = {qy_q[38:0], ~ty[40]};
  assign qzn = {qz_q[38:0], ~tz[40]};

  // stored centroid and radius
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [31:0]        rad_q;

  // sqrt state
  logic [63:0] sv_q, sr_q, sb_q;
  logic [63:0] best_q;
  logic        sat_q;
  logic        sq_busy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIVST) begin
      neg_q <= {sz_q[39], sy_q[39], sx_q[39]};
      qx_q <= sx_q[39] ? -sx_q : sx_q;
      qy_q <= sy_q[39] ? -sy_q : sy_q;
      qz_q <= sz_q[39] ? -sz_q : sz_q;
      rx_q <= '0; ry_q <= '0; rz_q <= '0;
      dcnt_q <= 6'd40;
    end else if (cmd_i.op == OP_DIVSTEP && dcnt_q != 6'd0) begin
      dcnt_q <= dcnt_q - 6'd1;
      if (!tx[40]) begin rx_q <= tx[39:0]; qx_q <= {qx_q[38:0], 1'b1}; end
      else begin rx_q <= {rx_q[38:0], qx_q[39]}; qx_q <= {qx_q[38:0], 1'b0}; end
      if (!ty[40]) begin ry_q <= ty[39:0]; qy_q <= {qy_q[38:0], 1'b1}; end
      else begin ry_q <= {ry_q[38:0], qy_q[39]}; qy_q <= {qy_q[38:0], 1'b0}; end
      if (!tz[40]) begin rz_q <= tz[39:0]; qz_q <= {qz_q[38:0], 1'b1}; end
      else begin rz_q <= {rz_q[38:0], qz_q[39]}; qz_q <= {qz_q[38:0], 1'b0}; end
      if (dcnt_q == 6'd1) begin
        cx_q <= neg_q[0] ? 32'(-qxn) : 32'(qxn);
        cy_q <= neg_q[1] ? 32'(-qyn) : 32'(qyn);
        cz_q <= neg_q[2] ? 32'(-qzn) : 32'(qzn);
      end
    end
  end

  // centroid reset on empty recompute
  logic signed [31:0] ocx, ocy, ocz;
  logic cen_rst_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cen_rst_q <= 1'b1;
    else if (cmd_i.op == OP_CLEAR && cmd_i.idx == 8'hFF) cen_rst_q <= 1'b1;
    else if (cmd_i.op == OP_DIVSTEP && dcnt_q == 6'd1) cen_rst_q <= 1'b0;
  end
  assign ocx = cen_rst_q ? 32'sd0 : cx_q;
  assign ocy = cen_rst_q ? 32'sd0 : cy_q;
  assign ocz = cen_rst_q ? 32'sd0 : cz_q;

  // distance pipe: stage 1 differences, stage 2 squares, stage 3 sum/compare
  logic        v1_q, v2_q;
  logic [32:0] dx_q, dy_q, dz_q;
  logic [63:0] ax_q, ay_q, az_q;
  logic signed [33:0] ddx, ddy, ddz;
  assign ddx = 34'(r_px) - 34'(ocx);
  assign ddy = 34'(r_py) - 34'(ocy);
  assign ddz = 34'(r_pz) - 34'(ocz);
  logic [65:0] dsum;
  assign dsum = {2'b0, ax_q} + {2'b0, ay_q} + {2'b0, az_q};
  logic [63:0] r2;
  assign r2 = {32'd0, crad_q} * {32'd0, crad_q};
  logic [63:0] r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      v1_q <= (cmd_i.op == OP_DIST);
      v2_q <= v1_q;
    end
  end

  logic fail_q;
  always_ff @(posedge clk_i) begin
    r2_q <= r2;
    if (cmd_i.op == OP_DIST) begin
      dx_q <= ddx[33] ? 33'(-ddx) : ddx[32:0];
      dy_q <= ddy[33] ? 33'(-ddy) : ddy[32:0];
      dz_q <= ddz[33] ? 33'(-ddz) : ddz[32:0];
    end
    if (v1_q) begin
      ax_q <= 64'({33'd0, dx_q} * {33'd0, dx_q});
      ay_q <= 64'({33'd0, dy_q} * {33'd0, dy_q});
      az_q <= 64'({33'd0, dz_q} * {33'd0, dz_q});
    end
    if (cmd_i.op == OP_CLEAR) begin
      best_q <= '0; sat_q <= 1'b0; fail_q <= 1'b0;
    end else if (v2_q) begin
      if (dsum[65:64] != 2'b0) begin sat_q <= 1'b1; fail_q <= 1'b1; end
      else begin
        if (dsum[63:0] > best_q) best_q <= dsum[63:0];
        if (dsum[63:0] > r2_q) fail_q <= 1'b1;
      end
    end
  end

  // bit-pair square root
  logic [63:0] sum_rb;
  assign sum_rb = sr_q + sb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= '0; sq_busy_q <= 1'b0;
    end else if (cmd_i.op == OP_CLEAR && cmd_i.idx == 8'hFF) begin
      rad_q <= '0;
    end else if (cmd_i.op == OP_SQST) begin
      sv_q <= best_q; sr_q <= '0; sb_q <= 64'd1 << 62; sq_busy_q <= 1'b1;
    end else if (cmd_i.op == OP_SQSTEP && sq_busy_q) begin
      if (sb_q == 64'd0) begin
        sq_busy_q <= 1'b0;
        rad_q <= sat_q ? 32'hFFFF_FFFF : sr_q[31:0];
      end else begin
        if (sv_q >= sum_rb) begin
          sv_q <= sv_q - sum_rb; sr_q <= (sr_q >> 1) + sb_q;
        end else sr_q <= sr_q >> 1;
        sb_q <= sb_q >> 2;
      end
    end
  end

  assign cx_o = ocx; assign cy_o = ocy; assign cz_o = ocz;
  assign radius_o = rad_q;

  assign sts_o.match = match_q;
  assign sts_o.done = (dcnt_q == 6'd0) && !sq_busy_q;
  assign sts_o.dist_ok = !v1_q && !v2_q;
  assign sts_o.fail = fail_q;

endmodule

`default_nettype wire

// ===== rtl/core/gcrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcrt_ctrl: command sequencer
// Walks the table for searches, shifts, sums and distance passes.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrt_ctrl import gcrt_pkg::*; #(
  parameter int unsigned MaxMembers = MaxMembersDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [2:0] command_i,
  input  wire dp_sts_t    sts_i,
  input  wire logic [7:0] total_i,
  output      dp_cmd_t    cmd_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       all_within_o,
  output      logic [1:0] status_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SRD   = 12'b000000000010, // address issued, wait RAM
    S_SCMP  = 12'b000000000100, // compare
    S_SRES  = 12'b000000001000, // decide
    S_MOD   = 12'b000000010000, // RAM read of slot, then write
    S_SHIFT = 12'b000000100000,
    S_SUM   = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_DIST  = 12'b000100000000,
    S_DRAIN = 12'b001000000000,
    S_SQRT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] idx_q, idx_d;
  cmd_e       cmd_q, cmd_d;
  logic [1:0] stat_q, stat_d;
  logic       all_q, all_d;
  logic       mod_ph_q, mod_ph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; idx_q <= '0; cmd_q <= CMD_ADD;
      stat_q <= ST_DONE; all_q <= 1'b0; mod_ph_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; cmd_q <= cmd_d;
      stat_q <= stat_d; all_q <= all_d; mod_ph_q <= mod_ph_d;
    end
  end

  always_comb begin
    state_d = state_q; idx_d = idx_q; cmd_d = cmd_q;
    stat_d = stat_q; all_d = all_q; mod_ph_d = mod_ph_q;
    cmd_o = '{op: OP_NONE, idx: idx_q, coh: 1'b0, dec: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cmd_d = cmd_e'(command_i);
          stat_d = ST_DONE; all_d = 1'b0; idx_d = '0; mod_ph_d = 1'b0;
          unique case (cmd_e'(command_i)) inside
            CMD_ADD, CMD_REMOVE, CMD_SET_ROLE, CMD_SET_POS, CMD_SET_HLTH:
              state_d = S_SRD;
            CMD_RECOMP, CMD_COHESION: state_d = S_SUM;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SRD: begin
        if (idx_q >= total_i || idx_q >= 8'(MaxMembers)) begin
          // not found
          if (cmd_q == CMD_ADD) begin
            if (total_i >= 8'(MaxMembers)) stat_d = ST_IGNORED;
            else cmd_o.op = OP_APPEND;
          end else stat_d = ST_NOTFOUND;
          state_d = S_OUT;
        end else state_d = S_SCMP;
      end
      S_SCMP: begin
        cmd_o.op = OP_SRCH; state_d = S_SRES;
      end
      S_SRES: begin
        if (sts_i.match) begin
          if (cmd_q == CMD_ADD) begin stat_d = ST_IGNORED; state_d = S_OUT; end
          else if (cmd_q == CMD_REMOVE) begin
            idx_d = idx_q + 8'd1; state_d = S_SHIFT; mod_ph_d = 1'b0;
          end else state_d = S_MOD;
        end else begin
          idx_d = idx_q + 8'd1; state_d = S_SRD;
        end
      end
      S_MOD: begin
        // RAM output still holds the slot entry
        unique case (cmd_q)
          CMD_SET_ROLE: cmd_o.op = OP_ROLE;
          CMD_SET_POS:  cmd_o.op = OP_POS;
          default:      cmd_o.op = OP_HLTH;
        endcase
        state_d = S_OUT;
      end
      S_SHIFT: begin
        // phase 0: read idx; phase 1: write into idx-1
        if (!mod_ph_q) begin
          if (idx_q >= total_i) begin
            cmd_o.dec = 1'b1; state_d = S_OUT;
          end else mod_ph_d = 1'b1;
        end else begin
          cmd_o.op = OP_SHIFT; cmd_o.idx = idx_q - 8'd1;
          idx_d = idx_q + 8'd1; mod_ph_d = 1'b0;
        end
      end
      S_SUM: begin
        if (total_i == 8'd0) begin
          if (cmd_q == CMD_RECOMP) begin
            cmd_o.op = OP_CLEAR; cmd_o.idx = 8'hFF;
          end else all_d = 1'b1;
          state_d = S_OUT;
        end else if (cmd_q == CMD_COHESION) begin
          cmd_o.op = OP_CLEAR; idx_d = '0; mod_ph_d = 1'b0; state_d = S_DIST;
        end else begin
          // idx read issued, phase 1 accumulates
          if (!mod_ph_q) begin
            if (idx_q == 8'd0) cmd_o.op = OP_CLEAR;
            mod_ph_d = 1'b1;
          end else begin
            cmd_o.op = OP_SUM; mod_ph_d = 1'b0;
            if (idx_q + 8'd1 >= total_i) begin
              state_d = S_DIV;
              cmd_o.idx = idx_q;
            end
            idx_d = idx_q + 8'd1;
          end
        end
      end
      S_DIV: begin
        if (!mod_ph_q) begin cmd_o.op = OP_DIVST; mod_ph_d = 1'b1; end
        else if (sts_i.done) begin
          idx_d = '0; mod_ph_d = 1'b0; state_d = S_DIST;
          cmd_o.op = OP_CLEAR; cmd_o.idx = '0;
        end else cmd_o.op = OP_DIVSTEP;
      end
      S_DIST: begin
        if (!mod_ph_q) mod_ph_d = 1'b1;
        else begin
          cmd_o.op = OP_DIST; mod_ph_d = 1'b0;
          idx_d = idx_q + 8'd1;
          if (idx_q + 8'd1 >= total_i) state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.dist_ok) begin
          if (cmd_q == CMD_COHESION) begin
            all_d = !sts_i.fail; state_d = S_OUT;
          end else begin cmd_o.op = OP_SQST; state_d = S_SQRT; end
        end
      end
      S_SQRT: begin
        if (sts_i.done) state_d = S_OUT;
        else cmd_o.op = OP_SQSTEP;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign all_within_o = all_q;
  assign status_o = stat_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accept while result pending");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/group_centroid_radius_table_core.sv =====
// ----------------------------------------------------------------------------
// group_centroid_radius_table_core: member table with centroid and radius
// Sequencer plus datapath; one result item per command item.
// ----------------------------------------------------------------------------
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | command_i .. check_radius_i
// out     | out_valid_o/out_ready_i | centroid_*_o .. status_o
//
// Lookups scan the table one member at a time; remove then shifts each later
// member down; recompute sums, divides, takes distances and takes the square
// root in turn, paced by the single RAM read port and the bit-serial divider
// and root. Reset clears count, centroid and radius.
// One item in flight; a result waiting on out_ready_i holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module group_centroid_radius_table_core import gcrt_pkg::*; #(
  parameter int unsigned MaxMembers = MaxMembersDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [2:0]         command_i,
  input  wire logic [63:0]        entity_id_i,
  input  wire logic [3:0]         role_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] health_in_i,
  input  wire logic [31:0]        check_radius_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [31:0] centroid_x_o,
  output      logic signed [31:0] centroid_y_o,
  output      logic signed [31:0] centroid_z_o,
  output      logic [31:0]        enclosing_radius_o,
  output      logic [6:0]         count_now_o,
  output      logic               all_within_o,
  output      logic [1:0]         status_o
);

  dp_cmd_t    dp_cmd;
  dp_sts_t    dp_sts;
  logic [7:0] total;

  gcrt_ctrl #(.MaxMembers(MaxMembers)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i,
    .sts_i(dp_sts), .total_i(total), .cmd_o(dp_cmd),
    .out_valid_o, .out_ready_i, .all_within_o, .status_o
  );

  gcrt_datapath #(.MaxMembers(MaxMembers)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .entity_id_i, .role_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .health_in_i, .check_radius_i,
    .sts_o(dp_sts), .total_o(total),
    .cx_o(centroid_x_o), .cy_o(centroid_y_o), .cz_o(centroid_z_o),
    .radius_o(enclosing_radius_o)
  );

  assign count_now_o = total[6:0];

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= 8'(MaxMembers)) else $error("count over capacity");
  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> $stable(total)) else $error("count moved idle");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != ST_RSVD) else $error("bad status");
`endif

endmodule

`default_nettype wire

// ===== dv/centroid_table_checker.sv =====
// ----------------------------------------------------------------------------
// centroid_table_checker: result predictor and comparator for the table core
// Watches both channels, keeps its own copy of the member table, predicts the
// result item of every accepted command item and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module centroid_table_checker import gcrt_pkg::*; #(
  parameter int unsigned MaxMembers = MaxMembersDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [2:0]         command_i,
  input  wire logic [63:0]        entity_id_i,
  input  wire logic [3:0]         role_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] health_in_i,
  input  wire logic [31:0]        check_radius_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] centroid_x_i,
  input  wire logic signed [31:0] centroid_y_i,
  input  wire logic signed [31:0] centroid_z_i,
  input  wire logic [31:0]        enclosing_radius_i,
  input  wire logic [6:0]         count_now_i,
  input  wire logic               all_within_i,
  input  wire logic [1:0]         status_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        radius;
    logic [6:0]         count;
    logic               all_in;
    status_e            status;
  } table_result_t;

  logic [63:0]        ids   [MaxMembers];
  logic signed [31:0] px    [MaxMembers];
  logic signed [31:0] py    [MaxMembers];
  logic signed [31:0] pz    [MaxMembers];
  logic [3:0]         roles [MaxMembers];
  logic [16:0]        health[MaxMembers];
  int                 total;
  logic signed [31:0] cen_x, cen_y, cen_z;
  logic [31:0]        radius_q;

  table_result_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic logic [31:0] floor_sqrt64(logic [63:0] v);
    logic [63:0] r, bit_q;
    r = '0;
    bit_q = 64'h1 << 62;
    while (bit_q > v) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (v >= r + bit_q) begin
        v = v - (r + bit_q);
        r = (r >> 1) + bit_q;
      end else begin
        r = r >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return r[31:0];
  endfunction

  // squared distance of one member; bit 64 set means it reached 2^64
  function automatic logic [64:0] member_dist_sq(int i, longint cx, longint cy, longint cz);
    longint       dx, dy, dz;
    logic [129:0] acc;
    dx = longint'(px[i]) - cx;
    dy = longint'(py[i]) - cy;
    dz = longint'(pz[i]) - cz;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    acc = 130'(dx) * 130'(dx) + 130'(dy) * 130'(dy) + 130'(dz) * 130'(dz);
    return (acc[129:64] != 0) ? {1'b1, 64'h0} : {1'b0, acc[63:0]};
  endfunction

  task automatic apply_command(output table_result_t res);
    int          slot;
    cmd_e        c;
    longint      sx, sy, sz, h;
    logic [64:0] d2;
    logic [63:0] best, r2;
    logic        sat;
    c = cmd_e'(command_i);
    res.all_in = 1'b0;
    res.status = ST_DONE;
    slot = -1;
    if (c <= CMD_SET_HLTH) begin
      for (int i = 0; i < total; i++) begin
        if (ids[i] == entity_id_i && slot < 0) slot = i;
      end
    end
    case (c)
      CMD_ADD: begin
        if (total >= MaxMembers || slot >= 0) begin
          res.status = ST_IGNORED;
        end else begin
          ids[total] = entity_id_i;
          roles[total] = role_i;
          px[total] = '0;
          py[total] = '0;
          pz[total] = '0;
          health[total] = HealthOne;
          total++;
        end
      end
      CMD_REMOVE, CMD_SET_ROLE, CMD_SET_POS, CMD_SET_HLTH: begin
        if (slot < 0) begin
          res.status = ST_NOTFOUND;
        end else if (c == CMD_REMOVE) begin
          // close the gap, keep insertion order
          for (int i = slot; i + 1 < total; i++) begin
            ids[i] = ids[i+1];
            px[i] = px[i+1];
            py[i] = py[i+1];
            pz[i] = pz[i+1];
            roles[i] = roles[i+1];
            health[i] = health[i+1];
          end
          total--;
        end else if (c == CMD_SET_ROLE) begin
          roles[slot] = role_i;
        end else if (c == CMD_SET_POS) begin
          px[slot] = pos_x_i;
          py[slot] = pos_y_i;
          pz[slot] = pos_z_i;
        end else begin
          h = longint'(health_in_i);
          if (h < 0) h = 0;
          if (h > longint'(HealthOne)) h = longint'(HealthOne);
          health[slot] = h[16:0];
        end
      end
      CMD_RECOMP: begin
        if (total == 0) begin
          cen_x = '0;
          cen_y = '0;
          cen_z = '0;
          radius_q = '0;
        end else begin
          sx = 0;
          sy = 0;
          sz = 0;
          for (int i = 0; i < total; i++) begin
            sx += longint'(px[i]);
            sy += longint'(py[i]);
            sz += longint'(pz[i]);
          end
          cen_x = 32'(sx / longint'(total));
          cen_y = 32'(sy / longint'(total));
          cen_z = 32'(sz / longint'(total));
          best = '0;
          sat = 1'b0;
          for (int i = 0; i < total; i++) begin
            d2 = member_dist_sq(i, longint'(cen_x), longint'(cen_y), longint'(cen_z));
            if (d2[64]) sat = 1'b1;
            else if (d2[63:0] > best) best = d2[63:0];
          end
          radius_q = sat ? 32'hFFFF_FFFF : floor_sqrt64(best);
        end
      end
      CMD_COHESION: begin
        r2 = 64'(check_radius_i) * 64'(check_radius_i);
        res.all_in = 1'b1;
        for (int i = 0; i < total; i++) begin
          d2 = member_dist_sq(i, longint'(cen_x), longint'(cen_y), longint'(cen_z));
          if (d2[64] || d2[63:0] > r2) res.all_in = 1'b0;
        end
      end
      default: ;
    endcase
    res.cx = cen_x;
    res.cy = cen_y;
    res.cz = cen_z;
    res.radius = radius_q;
    res.count = 7'(total);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t exp_r, act_r;
    if (!rst_ni) begin
      total = 0;
      cen_x = '0;
      cen_y = '0;
      cen_z = '0;
      radius_q = '0;
      mismatch_count_o <= 0;
      expected_results.delete();
    end else begin
      // compare first: a result leaving now belongs to an earlier item
      if (out_valid_i && out_ready_i) begin
        act_r = '{centroid_x_i, centroid_y_i, centroid_z_i, enclosing_radius_i,
                  count_now_i, all_within_i, status_e'(status_i)};
        if (expected_results.size() == 0) begin
          if (mismatch_count_o < 10) $display("unexpected result item %p", act_r);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (act_r != exp_r) begin
            if (mismatch_count_o < 10) begin
              $display("result mismatch: expected %p", exp_r);
              $display("                 actual   %p", act_r);
            end
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(exp_r);
        expected_results = {expected_results, exp_r};
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the group centroid/radius table core
// Drives directed then random command items with random idling on both
// channels; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import gcrt_pkg::*; ;

  localparam int NumRandom  = 1300;
  localparam int IdPoolSize = 96;
  localparam int StallLimit = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         command_i;
  logic [63:0]        entity_id_i;
  logic [3:0]         role_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [31:0] health_in_i;
  logic [31:0]        check_radius_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] centroid_x_o, centroid_y_o, centroid_z_o;
  logic [31:0]        enclosing_radius_o;
  logic [6:0]         count_now_o;
  logic               all_within_o;
  logic [1:0]         status_o;
  int                 mismatch_count;
  int                 pending_results;
  logic               no_idle;      // long stretch with no idling on either side
  int                 quiet_cycles = 0;
  logic [63:0]        id_pool[IdPoolSize];

  group_centroid_radius_table_core u_top (.*);

  centroid_table_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .entity_id_i, .role_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .health_in_i, .check_radius_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .centroid_x_i(centroid_x_o), .centroid_y_i(centroid_y_o),
    .centroid_z_i(centroid_z_o), .enclosing_radius_i(enclosing_radius_o),
    .count_now_i(count_now_o), .all_within_i(all_within_o), .status_i(status_o),
    .mismatch_count_o(mismatch_count), .pending_o(pending_results)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Receiver: stall about a quarter of the cycles, never during the quiet run.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 25);
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until the core takes it. Called at a rising
  // edge; returns at the edge where the item was accepted.
  task automatic send_item(input cmd_e c, input logic [63:0] id, input logic [3:0] role,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] hp,
                           input logic [31:0] rad);
    in_valid_i <= 1'b1;
    command_i <= c;
    entity_id_i <= id;
    role_i <= role;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    health_in_i <= hp;
    check_radius_i <= rad;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // Drop valid for a random stretch about a quarter of the time.
  task automatic maybe_idle();
    if (!no_idle && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom();
      default: return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(32'h0006_0000);
    endcase
  endfunction

  // Random content on every field, so all input bits toggle whatever the command.
  task automatic send_random(input cmd_e c);
    logic [63:0] id;
    id = ($urandom_range(19) == 0) ? {$urandom(), $urandom()}
                                   : id_pool[$urandom_range(IdPoolSize - 1)];
    send_item(c, id, 4'($urandom()), pick_coord(), pick_coord(), pick_coord(),
              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0001_2000),
              pick_radius());
  endtask

  function automatic cmd_e pick_command(int mode);
    int w;
    w = $urandom_range(99);
    case (mode)
      0:       return (w < 45) ? CMD_ADD : (w < 55) ? CMD_REMOVE : (w < 65) ? CMD_SET_POS
                    : (w < 72) ? CMD_SET_ROLE : (w < 79) ? CMD_SET_HLTH
                    : (w < 88) ? CMD_RECOMP : (w < 97) ? CMD_COHESION : CMD_UNUSED;
      1:       return (w < 15) ? CMD_ADD : (w < 45) ? CMD_REMOVE : (w < 60) ? CMD_SET_POS
                    : (w < 66) ? CMD_SET_ROLE : (w < 72) ? CMD_SET_HLTH
                    : (w < 84) ? CMD_RECOMP : (w < 97) ? CMD_COHESION : CMD_UNUSED;
      default: return (w < 20) ? CMD_ADD : (w < 30) ? CMD_REMOVE : (w < 55) ? CMD_SET_POS
                    : (w < 61) ? CMD_SET_ROLE : (w < 67) ? CMD_SET_HLTH
                    : (w < 82) ? CMD_RECOMP : (w < 97) ? CMD_COHESION : CMD_UNUSED;
    endcase
  endfunction

  initial begin
    int   mode;
    logic [63:0] all_ones;
    all_ones = '1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_UNUSED;
    entity_id_i = '0;
    role_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    health_in_i = '0;
    check_radius_i = '0;
    no_idle = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = all_ones;
    for (int i = 2; i < IdPoolSize; i++) id_pool[i] = {$urandom(), $urandom()};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table cases, extreme ids and coordinates, clamping,
    // largest check radius, duplicate add, missing id, unused command code.
    send_item(CMD_RECOMP, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_COHESION, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_REMOVE, 64'd5, '0, '0, '0, '0, '0, '0);
    send_item(CMD_ADD, '0, 4'hF, '0, '0, '0, '0, '0);
    send_item(CMD_ADD, all_ones, 4'h0, '0, '0, '0, '0, '0);
    send_item(CMD_ADD, all_ones, 4'h3, '0, '0, '0, '0, '0);
    send_item(CMD_SET_ROLE, all_ones, 4'hF, '0, '0, '0, '0, '0);
    send_item(CMD_SET_POS, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              '0, '0);
    send_item(CMD_SET_POS, all_ones, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              '0, '0);
    send_item(CMD_SET_HLTH, '0, '0, '0, '0, '0, 32'h8000_0000, '0);
    send_item(CMD_SET_HLTH, all_ones, '0, '0, '0, '0, 32'h7FFF_FFFF, '0);
    send_item(CMD_SET_HLTH, all_ones, '0, '0, '0, '0, 32'h0000_8000, '0);
    send_item(CMD_RECOMP, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_COHESION, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_COHESION, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_SET_POS, all_ones, '0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001,
              '0, '0);
    send_item(CMD_SET_ROLE, 64'd77, 4'h5, '0, '0, '0, '0, '0);
    send_item(CMD_SET_POS, 64'd77, '0, '0, '0, '0, '0, '0);
    send_item(CMD_SET_HLTH, 64'd77, '0, '0, '0, '0, '0, '0);
    send_item(CMD_RECOMP, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_COHESION, '0, '0, '0, '0, '0, '0, 32'h0001_0000);
    send_item(CMD_UNUSED, all_ones, 4'hF, '1, '1, '1, '1, '1);
    send_item(CMD_REMOVE, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_REMOVE, all_ones, '0, '0, '0, '0, '0, '0);
    send_item(CMD_RECOMP, '0, '0, '0, '0, '0, '0, '0);

    // Random: phases that fill the table, drain it, and work a full table.
    mode = 0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 130 == 0) mode = (mode + 1) % 3;
      no_idle = (n >= 500 && n < 700);
      if (n == 300 || n == 900) begin
        // hold the next item until every result has come back
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results != 0) @(posedge clk_i);
      end
      maybe_idle();
      send_random(pick_command(mode));
    end

    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
